>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the clock time set controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop in the same cycle as cond, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error(msg);

// Check prop in the cycle after cond, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> src/ctsc_pkg.sv
// ----------------------------------------------------------------------------
// ctsc_pkg
// Types, codes and tables shared by the clock time set controller.
// ----------------------------------------------------------------------------
package ctsc_pkg;

	typedef enum logic [1:0] {
		OP_TURN   = 2'd0,
		OP_BUTTON = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_SHOW         = 2'd0,
		MODE_EDIT_HOURS   = 2'd1,
		MODE_EDIT_MINUTES = 2'd2,
		MODE_COMMIT_WAIT  = 2'd3
	} mode_t;

	// channel codes in a colour table entry
	localparam logic [1:0] CODE_HALF = 2'd1;
	localparam logic [1:0] CODE_FULL = 2'd2;

	localparam logic [5:0] HOUR_LAST      = 6'd23;
	localparam logic [5:0] HOURS_PER_DAY  = 6'd24;
	localparam logic [6:0] MINUTE_LAST    = 7'd59;
	localparam logic [6:0] MINUTES_PER_HR = 7'd60;
	localparam logic [6:0] MINUTE_CARRY   = 7'd100;
	localparam logic [3:0] LEVEL_MAX      = 4'd15;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd30;

	// x / 100 for x < 4096 as (x * 5243) >> 19
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	localparam logic [3:0] MASK_SHOW    = 4'b0000;
	localparam logic [3:0] MASK_HOURS   = 4'b0011;
	localparam logic [3:0] MASK_MINUTES = 4'b1100;
	localparam logic [3:0] MASK_STORE   = 4'b1111;

	localparam logic [5:0] COLOR_CODES [32] = '{
		6'h01, 6'h02, 6'h04, 6'h05, 6'h06, 6'h08, 6'h09, 6'h0A,
		6'h10, 6'h11, 6'h12, 6'h14, 6'h15, 6'h16, 6'h18, 6'h19, 6'h1A,
		6'h20, 6'h21, 6'h22, 6'h24, 6'h25, 6'h26, 6'h28, 6'h29, 6'h2A,
		6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00
	};

	typedef struct packed {
		logic [1:0]        op;
		logic signed [1:0] step;
		logic              button_down;
		logic              new_second;
		logic [11:0]       rtc_time;
		logic [5:0]        rtc_hours;
		logic [6:0]        rtc_minutes;
	} item_t;

	typedef struct packed {
		logic [1:0]  mode_now;
		logic [11:0] display_value;
		logic [4:0]  base_color_index;
		logic [7:0]  blink_red;
		logic [7:0]  blink_green;
		logic [7:0]  blink_blue;
		logic [3:0]  blink_digits;
		logic        store_strobe;
		logic [11:0] store_value;
	} result_t;

	// hours * 100 + minutes with shifts and adds
	function automatic logic [11:0] join_time(logic [5:0] hours, logic [6:0] minutes);
		logic [11:0] h;
		h = {6'd0, hours};
		return (h << 6) + (h << 5) + (h << 2) + {5'd0, minutes};
	endfunction

	function automatic logic [7:0] chan_level(logic [1:0] code, logic [7:0] lvl);
		logic [7:0] r;
		case (code)
			CODE_HALF: r = lvl >> 1;
			CODE_FULL: r = lvl;
			default:   r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/ctsc_cmd_if.sv
// ----------------------------------------------------------------------------
// ctsc_cmd_if
// Event channel: turns, button edges and ticks with clock time.
// ----------------------------------------------------------------------------
interface ctsc_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [1:0] step;
	logic              button_down;
	logic              new_second;
	logic [11:0]       rtc_time;

	modport source (output valid, output op, output step, output button_down,
		output new_second, output rtc_time, input ready);
	modport sink (input valid, input op, input step, input button_down,
		input new_second, input rtc_time, output ready);
endinterface

>>> src/ctsc_disp_if.sv
// ----------------------------------------------------------------------------
// ctsc_disp_if
// Result channel: display state and committed time.
// ----------------------------------------------------------------------------
interface ctsc_disp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode_now;
	logic [11:0] display_value;
	logic [4:0]  base_color_index;
	logic [7:0]  blink_red;
	logic [7:0]  blink_green;
	logic [7:0]  blink_blue;
	logic [3:0]  blink_digits;
	logic        store_strobe;
	logic [11:0] store_value;

	modport source (output valid, output mode_now, output display_value,
		output base_color_index, output blink_red, output blink_green,
		output blink_blue, output blink_digits, output store_strobe,
		output store_value, input ready);
	modport sink (input valid, input mode_now, input display_value,
		input base_color_index, input blink_red, input blink_green,
		input blink_blue, input blink_digits, input store_strobe,
		input store_value, output ready);
endinterface

>>> src/clock_time_set_controller.sv
// ----------------------------------------------------------------------------
// clock_time_set_controller
// Mode, time setting and digit colour animation of a four-digit clock.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  (sink)   takes one word per event: encoder turn, button edge, or a
//                 100 ms tick that may carry a fresh clock time.
//   disp (source) gives one word per event: mode, time to show, user colour,
//                 animated colour and digit mask, and the commit strobe.
//   cfg_we/cfg_wdata write the idle timeout in ticks; write only while idle.
// Pipeline: the cmd word is registered in the input stage and its result in
//   the output register, which drives disp.
//   Stage one registers the event and splits the clock time into hours and
//   minutes with a reciprocal multiply; stage two applies the event to the
//   state and loads the output register.
// Throughput: one word per cycle while disp is taken; the state update is a
//   single pass of compares and small adds, so back-to-back events are taken.
// Stall: when disp is not taken, the output word holds, the input register
//   holds its word, and cmd.ready stays low while that word waits.
// Reset: show mode, all times, levels and colour indices zero, animation
//   rising, timeout 30 ticks; both channels empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clock_time_set_controller #(
	parameter int COLOR_COUNT = 26
) (
	input  logic       clk,
	input  logic       arst_n,
	ctsc_cmd_if.sink   cmd,
	ctsc_disp_if.source disp,
	input  logic       cfg_we,
	input  logic [15:0] cfg_wdata
);
	import ctsc_pkg::*;

	logic        item_valid;
	item_t       item;
	logic        advance;
	result_t     res;
	logic [15:0] timeout_q;
	logic        out_valid_q;
	result_t     out_q;

	// move the staged word on whenever the output register is free or drains
	assign advance = item_valid && (!out_valid_q || disp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	ctsc_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	ctsc_core #(
		.COLOR_COUNT (COLOR_COUNT)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item          (item),
		.timeout_ticks (timeout_q),
		.res           (res)
	);

	// output register: hold while stalled, load on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || disp.ready) begin
			out_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign disp.valid            = out_valid_q;
	assign disp.mode_now         = out_q.mode_now;
	assign disp.display_value    = out_q.display_value;
	assign disp.base_color_index = out_q.base_color_index;
	assign disp.blink_red        = out_q.blink_red;
	assign disp.blink_green      = out_q.blink_green;
	assign disp.blink_blue       = out_q.blink_blue;
	assign disp.blink_digits     = out_q.blink_digits;
	assign disp.store_strobe     = out_q.store_strobe;
	assign disp.store_value      = out_q.store_value;

	// a commit always lands back in show mode
	`ASSERT_IMPLIES(a_commit_in_show, clk, arst_n, disp.valid && disp.store_strobe,
		disp.mode_now == MODE_SHOW, "commit outside show mode")

	// show mode draws no animated digits
	`ASSERT_IMPLIES(a_show_no_blink, clk, arst_n, disp.valid && disp.mode_now == MODE_SHOW,
		disp.blink_digits == MASK_SHOW, "animated digits in show mode")

	// the committed time is what show mode displays
	`ASSERT_IMPLIES(a_commit_shown, clk, arst_n, disp.valid && disp.store_strobe,
		disp.display_value == disp.store_value, "committed time not displayed")

	// a staged word with a free output is in the output register in the cycle after
	`ASSERT_NEXT(a_stage_drains, clk, arst_n, item_valid && !out_valid_q,
		out_valid_q, "staged word not moved to the output")

endmodule

>>> src/ctsc_in_stage.sv
// ----------------------------------------------------------------------------
// ctsc_in_stage
// Input register; splits the clock time into hours and minutes on the way in.
// ----------------------------------------------------------------------------
module ctsc_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	ctsc_cmd_if.sink       cmd,
	input  logic           advance,
	output logic           item_valid,
	output ctsc_pkg::item_t item
);
	import ctsc_pkg::*;

	logic [24:0] prod;
	logic [5:0]  hours;
	logic [11:0] rem;
	logic        valid_s1;
	item_t       item_s1;

	assign prod  = {13'd0, cmd.rtc_time} * {12'd0, DIV100_MUL};
	assign hours = prod[DIV100_SHIFT +: 6];
	assign rem   = cmd.rtc_time - join_time(hours, 7'd0);

	assign cmd.ready  = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.op          <= cmd.op;
			item_s1.step        <= cmd.step;
			item_s1.button_down <= cmd.button_down;
			item_s1.new_second  <= cmd.new_second;
			item_s1.rtc_time    <= cmd.rtc_time;
			item_s1.rtc_hours   <= hours;
			item_s1.rtc_minutes <= rem[6:0];
		end
	end

endmodule

>>> src/ctsc_core.sv
// ----------------------------------------------------------------------------
// ctsc_core
// Mode, time and animation state; computes the next state and the result.
// ----------------------------------------------------------------------------
module ctsc_core #(
	parameter int COLOR_COUNT = 26
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  ctsc_pkg::item_t   item,
	input  logic [15:0]       timeout_ticks,
	output ctsc_pkg::result_t res
);
	import ctsc_pkg::*;

	localparam logic [4:0] COLOR_LAST = 5'(COLOR_COUNT - 1);
	localparam logic signed [6:0] COLOR_LIMIT = 7'(COLOR_COUNT);

	mode_t       mode_q, mode_n;
	logic [11:0] clock_q, clock_n;
	logic [5:0]  ch_q, ch_n;
	logic [6:0]  cm_q, cm_n;
	logic [5:0]  wh_q, wh_n;
	logic [6:0]  wm_q, wm_n;
	logic [3:0]  lvl_q, lvl_n;
	logic        rising_q, rising_n;
	logic [4:0]  aci_q, aci_n;
	logic [4:0]  uci_q, uci_n;
	logic [15:0] idle_q, idle_n;
	logic [7:0]  red_q, red_n, green_q, green_n, blue_q, blue_n;
	logic        strobe;
	logic [11:0] work_time;

	assign work_time = join_time(wh_q, wm_q);

	always_comb begin
		logic signed [6:0] inc;
		logic signed [6:0] idx;
		logic signed [7:0] ht;
		logic signed [7:0] mt;
		logic [7:0]        mu;
		logic [7:0]        lvl8;
		logic [5:0]        code;
		mode_t             target;

		mode_n   = mode_q;
		clock_n  = clock_q;
		ch_n     = ch_q;
		cm_n     = cm_q;
		wh_n     = wh_q;
		wm_n     = wm_q;
		lvl_n    = lvl_q;
		rising_n = rising_q;
		aci_n    = aci_q;
		uci_n    = uci_q;
		idle_n   = idle_q;
		red_n    = red_q;
		green_n  = green_q;
		blue_n   = blue_q;
		strobe   = 1'b0;
		target   = mode_q;
		inc      = {{5{item.step[1]}}, item.step};
		idx      = $signed({2'b00, uci_q}) + inc;
		ht       = $signed({2'b00, wh_q}) + {inc[6], inc};
		mt       = $signed({1'b0, wm_q}) + {inc[6], inc};
		mu       = 8'd0;
		lvl8     = {lvl_q, 4'hF};
		code     = 6'd0;

		case (item.op)
			OP_TURN: begin
				idle_n = 16'd0;
				case (mode_q)
					MODE_SHOW: begin
						if (idx < 7'sd0 || idx >= COLOR_LIMIT) begin
							uci_n = (inc > 7'sd0) ? 5'd0 : COLOR_LAST;
						end else begin
							uci_n = idx[4:0];
						end
					end
					MODE_EDIT_HOURS: begin
						if (wh_q == 6'd0 && inc < 7'sd0) begin
							wh_n = HOUR_LAST;
						end else if (ht < 8'sd0) begin
							wh_n = 6'(ht + 8'(HOURS_PER_DAY));
						end else if (ht >= $signed({2'b00, HOURS_PER_DAY})) begin
							wh_n = 6'(ht - 8'(HOURS_PER_DAY));
						end else begin
							wh_n = ht[5:0];
						end
					end
					MODE_EDIT_MINUTES: begin
						if (mt < 8'sd0) begin
							wm_n = MINUTE_LAST;
						end else begin
							// carry into the hour at one hundred, then fold 60..99
							mu = mt;
							if (mu >= {1'b0, MINUTE_CARRY}) begin
								mu   = mu - {1'b0, MINUTE_CARRY};
								wh_n = wh_q + 6'd1;
							end
							if (mu >= {1'b0, MINUTES_PER_HR}) begin
								mu = mu - {1'b0, MINUTES_PER_HR};
							end
							wm_n = mu[6:0];
						end
					end
					default: ;
				endcase
			end
			OP_BUTTON: begin
				idle_n = 16'd0;
				case (mode_q)
					MODE_SHOW:         if (!item.button_down) target = MODE_EDIT_HOURS;
					MODE_EDIT_HOURS:   if (!item.button_down) target = MODE_EDIT_MINUTES;
					MODE_EDIT_MINUTES: if (item.button_down) target = MODE_COMMIT_WAIT;
					default: begin
						if (!item.button_down) begin
							if (lvl_q == 4'd0 && wh_q < HOURS_PER_DAY && wm_q < MINUTES_PER_HR) begin
								clock_n = work_time;
								ch_n    = wh_q;
								cm_n    = wm_q;
								strobe  = 1'b1;
							end
							target = MODE_SHOW;
						end
					end
				endcase
			end
			OP_TICK: begin
				idle_n = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
				if (item.new_second) begin
					clock_n = item.rtc_time;
					ch_n    = item.rtc_hours;
					cm_n    = item.rtc_minutes;
					if (mode_q != MODE_SHOW && idle_n >= timeout_ticks) begin
						target = MODE_SHOW;
					end
				end
			end
			default: ;
		endcase

		// mode entry side effects
		if (target != mode_q) begin
			if (target == MODE_EDIT_HOURS || target == MODE_EDIT_MINUTES) begin
				if (target == MODE_EDIT_HOURS) begin
					wh_n = ch_q;
					wm_n = cm_q;
				end
				lvl_n    = 4'd0;
				rising_n = 1'b1;
				aci_n    = 5'd0;
				red_n    = 8'd0;
				green_n  = 8'd0;
				blue_n   = 8'd0;
			end else if (target == MODE_COMMIT_WAIT) begin
				lvl_n = LEVEL_MAX;
			end
		end
		mode_n = target;

		// animation step on ticks outside show mode
		if (item.op == OP_TICK && mode_n != MODE_SHOW) begin
			lvl8    = {lvl_n, 4'hF};
			code    = COLOR_CODES[aci_n];
			red_n   = chan_level(code[1:0], lvl8);
			green_n = chan_level(code[3:2], lvl8);
			blue_n  = chan_level(code[5:4], lvl8);
			if (mode_n == MODE_COMMIT_WAIT) begin
				if (lvl_n != 4'd0) lvl_n = lvl_n - 4'd1;
			end else begin
				if (lvl_n >= LEVEL_MAX) begin
					rising_n = 1'b0;
				end else if (lvl_n == 4'd0) begin
					rising_n = 1'b1;
					aci_n    = (aci_n == COLOR_LAST) ? 5'd0 : aci_n + 5'd1;
				end
				lvl_n = rising_n ? lvl_n + 4'd1 : lvl_n - 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SHOW;
			clock_q  <= 12'd0;
			ch_q     <= 6'd0;
			cm_q     <= 7'd0;
			wh_q     <= 6'd0;
			wm_q     <= 7'd0;
			lvl_q    <= 4'd0;
			rising_q <= 1'b1;
			aci_q    <= 5'd0;
			uci_q    <= 5'd0;
			idle_q   <= 16'd0;
			red_q    <= 8'd0;
			green_q  <= 8'd0;
			blue_q   <= 8'd0;
		end else if (advance) begin
			mode_q   <= mode_n;
			clock_q  <= clock_n;
			ch_q     <= ch_n;
			cm_q     <= cm_n;
			wh_q     <= wh_n;
			wm_q     <= wm_n;
			lvl_q    <= lvl_n;
			rising_q <= rising_n;
			aci_q    <= aci_n;
			uci_q    <= uci_n;
			idle_q   <= idle_n;
			red_q    <= red_n;
			green_q  <= green_n;
			blue_q   <= blue_n;
		end
	end

	always_comb begin
		res.mode_now         = mode_n;
		res.display_value    = (mode_n == MODE_SHOW) ? clock_n : join_time(wh_n, wm_n);
		res.base_color_index = uci_n;
		res.blink_red        = red_n;
		res.blink_green      = green_n;
		res.blink_blue       = blue_n;
		res.store_strobe     = strobe;
		res.store_value      = strobe ? work_time : 12'd0;
		unique case (mode_n)
			MODE_SHOW:         res.blink_digits = MASK_SHOW;
			MODE_EDIT_HOURS:   res.blink_digits = MASK_HOURS;
			MODE_EDIT_MINUTES: res.blink_digits = MASK_MINUTES;
			default:           res.blink_digits = MASK_STORE;
		endcase
	end

endmodule
